/* design/dmm_pkg.sv */
`timescale 1ns / 1ps

package dmm_pkg;

   localparam int MAX_SIZE   = 16;
   localparam int IDX_W      = 4;
   localparam int ADDR_W     = 2 * IDX_W;
   localparam int DEPTH      = MAX_SIZE * MAX_SIZE;
   localparam int SIZE_W     = 5;
   localparam int ELEM_W     = 16;
   localparam int PROD_W     = 2 * ELEM_W;
   localparam int SUM_W      = 40;

   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(16);
   localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(MAX_SIZE);

   typedef enum logic [1:0] {
      FUNC_LOAD_A  = 2'd0,
      FUNC_LOAD_B  = 2'd1,
      FUNC_COMPUTE = 2'd2,
      FUNC_NONE    = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      func_type                  func;
      logic [IDX_W-1:0]          row;
      logic [IDX_W-1:0]          col;
      logic signed [ELEM_W-1:0]  value;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]          out_row;
      logic [IDX_W-1:0]          out_col;
      logic signed [SUM_W-1:0]   sum;
      logic                      last;
   } rsp_type;

endpackage

/* design/dense_matrix_multiply.sv */
`timescale 1ns / 1ps

// Dense matrix multiply, one product row per compute request.
// The req channel carries load and compute requests (valid/ready). A load
// writes one element of A or B, and func 3 is dropped. A compute request
// for row r < n returns n results on the rsp channel, one per column in
// increasing order, with last set on column n-1.
// A compute of a row at or above n returns nothing.
// One multiply-accumulate unit, fed by one read port on each element store,
// does every product. Each column issues n reads and then drains the read,
// multiply and accumulate stages. req_ready is low for the whole row.
// The csr port sets n (reset 16; 0 acts as 1, values above 16 act as 16);
// the user must write it only while the block is idle; the block does not enforce it.
// Results sit in an output register; while the receiver stalls, the block
// finishes the next column and waits for that register to free up. After the
// last column is loaded there, new requests are taken again.
// Reset clears the control state and sets n to 16; the element stores are
// not cleared and hold nothing defined until written.
module dense_matrix_multiply (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  dmm_pkg::req_type           req,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output dmm_pkg::rsp_type           rsp,
   input  logic                       csr_write,
   input  logic [dmm_pkg::SIZE_W-1:0] csr_wdata
);
   import dmm_pkg::*;

   logic signed [ELEM_W-1:0] matrix_a [DEPTH];
   logic signed [ELEM_W-1:0] matrix_b [DEPTH];

   state_type               state_ff, state_in;
   logic [SIZE_W-1:0]       size_ff;
   logic [SIZE_W-1:0]       n_eff;
   logic [IDX_W-1:0]        row_ff;
   logic [IDX_W-1:0]        j_ff;
   logic [IDX_W-1:0]        k_ff;
   logic                    k_last;
   logic                    j_last;

   logic                    s1_valid_ff;
   logic                    s1_first_ff;
   logic signed [ELEM_W-1:0] a_q_ff;
   logic signed [ELEM_W-1:0] b_q_ff;
   logic                    s2_valid_ff;
   logic                    s2_first_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [SUM_W-1:0] acc_ff, acc_in;
   logic signed [SUM_W-1:0] prod_ext;

   logic                    rsp_valid_ff;
   rsp_type                 rsp_ff;

   logic                    req_acc;
   logic                    start;
   logic                    rd_en;
   logic                    rsp_free;
   logic                    pipe_empty;
   logic                    rsp_load;

   // Out-of-range sizes saturate: zero acts as one, above the store as full.
   always_comb begin
      if (size_ff == '0) begin
         n_eff = SIZE_W'(1);
      end else if (size_ff > SIZE_MAX) begin
         n_eff = SIZE_MAX;
      end else begin
         n_eff = size_ff;
      end
   end

   assign req_acc    = req_valid && req_ready;
   assign start      = req_acc && (req.func == FUNC_COMPUTE)
                       && ({1'b0, req.row} < n_eff);
   assign k_last     = ({1'b0, k_ff} == (n_eff - SIZE_W'(1)));
   assign j_last     = ({1'b0, j_ff} == (n_eff - SIZE_W'(1)));
   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign pipe_empty = !s1_valid_ff && !s2_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            if (k_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (pipe_empty && rsp_free) begin
               state_in = j_last ? ST_IDLE : ST_ISSUE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      rd_en     = 1'b0;
      rsp_load  = 1'b0;
      case (state_ff)
         ST_IDLE:  req_ready = 1'b1;
         ST_ISSUE: rd_en     = 1'b1;
         ST_DRAIN: rsp_load  = pipe_empty && rsp_free;
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         size_ff  <= SIZE_RESET;
      end else begin
         state_ff <= state_in;
         if (csr_write) begin
            size_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc && (req.func == FUNC_LOAD_A)) begin
         matrix_a[{req.row, req.col}] <= req.value;
      end
      if (rd_en) begin
         a_q_ff <= matrix_a[{row_ff, k_ff}];
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc && (req.func == FUNC_LOAD_B)) begin
         matrix_b[{req.row, req.col}] <= req.value;
      end
      if (rd_en) begin
         b_q_ff <= matrix_b[{k_ff, j_ff}];
      end
   end

   // Column and term counters of the sequencer.
   always_ff @(posedge clock) begin
      if (start) begin
         row_ff <= req.row;
         j_ff   <= '0;
         k_ff   <= '0;
      end else begin
         if (rd_en) begin
            k_ff <= k_last ? '0 : k_ff + IDX_W'(1);
         end
         if (rsp_load) begin
            j_ff <= j_ff + IDX_W'(1);
         end
      end
   end

   assign prod_ext = {{(SUM_W - PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
   assign acc_in   = s2_first_ff ? prod_ext : acc_ff + prod_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= rd_en;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_first_ff <= (k_ff == '0);
      s2_first_ff <= s1_first_ff;
      if (s1_valid_ff) begin
         prod_ff <= a_q_ff * b_q_ff;
      end
      if (s2_valid_ff) begin
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff.out_row <= row_ff;
         rsp_ff.out_col <= j_ff;
         rsp_ff.sum     <= acc_ff;
         rsp_ff.last    <= j_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

/* design/dmm_checker.sv */
`timescale 1ns / 1ps

module dmm_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input dmm_pkg::req_type           req,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input dmm_pkg::rsp_type           rsp,
   input logic                       csr_write,
   input logic [dmm_pkg::SIZE_W-1:0] csr_wdata
);
   import dmm_pkg::*;

   // A stalled result must hold until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
      else $error("stalled result changed or dropped");

   // After a load or an unused request, the block is ready again in the next cycle.
   a_load_one_cycle: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req.func != FUNC_COMPUTE) |=> req_ready)
      else $error("block stayed busy after a non-compute request");

   // While a row is only partly returned, no new request is taken.
   a_busy_mid_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp.last |-> !req_ready)
      else $error("block ready in the middle of a row");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A size write always carries a known value.
   a_csr_known: assert property (@(posedge clock) disable iff (reset)
      csr_write |-> !$isunknown(csr_wdata))
      else $error("unknown size written");

endmodule

bind dense_matrix_multiply dmm_checker u_dmm_checker (.*);
